@@ rtl/core/gsu_pkg.sv @@
// gsu_pkg: shared types, constants and the tanh table builder for the glauber spin update
// used by every module under rtl/core; no dependencies of its own
package gsu_pkg;

  localparam int FIELD_W = 22;
  localparam int PROD_W = FIELD_W + 16;
  localparam int TANH_ENTRIES_DEF = 256;
  localparam logic [15:0] BETA_RESET = 16'd4096;
  localparam logic [15:0] X_SAT = 16'd32768;
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

  typedef struct packed {
    logic signed [15:0] coupling;
    logic               neighbour_spin;
    logic               own_spin;
    logic [15:0]        random_fraction;
    logic               last_term;
  } term_t;

  typedef struct packed {
    logic        new_spin;
    logic        flipped;
    logic [16:0] flip_probability;
  } result_t;

  // site field, captured on the last term
  typedef struct packed {
    logic signed [FIELD_W-1:0] field;
    logic                      own_spin;
    logic [15:0]               random_fraction;
  } field_stage_t;

  // |field| * beta, before the shift down to Q4.12
  typedef struct packed {
    logic [PROD_W-1:0] product;
    logic              positive;
    logic              own_spin;
    logic [15:0]       random_fraction;
  } prod_stage_t;

  typedef struct packed {
    logic [15:0] tanh_value;
    logic        zero;
    logic        minus;
    logic        own_spin;
    logic [15:0] random_fraction;
  } tanh_stage_t;

  // restoring division, elaboration use only
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = num;
    r = '0;
    for (int k = 0; k < 64; k++) begin
      r = {r[62:0], q[63]};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-z in Q32: taylor series on z/16, then squared four times
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] zq);
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] v;
    f = zq >> 4;
    if (f >= ONE_Q32) f = ONE_Q32 - 64'd1;
    term = ONE_Q32;
    pos = ONE_Q32;
    neg = '0;
    for (int n = 1; n <= 24; n++) begin
      term = div_u64((term * f) >> 32, 64'(n));
      if ((n & 1) != 0) neg = neg + term;
      else pos = pos + term;
    end
    v = (pos > neg) ? pos - neg : 64'd0;
    if (v >= ONE_Q32) v = ONE_Q32 - 64'd1;
    for (int k = 0; k < 4; k++) begin
      v = (v * v) >> 32;
    end
    return v;
  endfunction

  // entry i: round(65536 * tanh((i + 0.5) * 8 / entries)), limited to 65535
  function automatic logic [15:0] tanh_entry(input int unsigned i, input int unsigned entries);
    logic [63:0] zq;
    logic [63:0] v;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] t;
    zq = div_u64((64'(2 * i + 1) * 64'd8) << 32, 64'(entries));
    v = exp_neg_q32(zq);
    num = ONE_Q32 - v;
    den = ONE_Q32 + v;
    t = div_u64((num << 16) + (den >> 1), den);
    if (t > 64'd65535) t = 64'd65535;
    return t[15:0];
  endfunction

endpackage

@@ rtl/core/gsu_accum.sv @@
// gsu_accum: saturating local field accumulator and the site field register
// depends on gsu_pkg
module gsu_accum
  import gsu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         term_valid,
  input  term_t        term,
  output logic         ready,
  output logic         site_valid,
  output field_stage_t site,
  input  logic         down_ready
);

  localparam logic signed [FIELD_W:0] SUM_MAX = (FIELD_W+1)'(2 ** (FIELD_W - 1) - 1);
  localparam logic signed [FIELD_W:0] SUM_MIN = -(FIELD_W+1)'(2 ** (FIELD_W - 1));

  logic signed [FIELD_W-1:0] field_sum;
  logic signed [FIELD_W-1:0] field_next;
  logic signed [FIELD_W:0]   term_val;
  logic signed [FIELD_W:0]   sum;
  logic                      accept;

  assign ready  = !site_valid || down_ready;
  assign accept = term_valid && ready;

  always_comb begin
    term_val = term.neighbour_spin ? (FIELD_W+1)'(term.coupling)
                                   : -((FIELD_W+1)'(term.coupling));
    sum = (FIELD_W+1)'(field_sum) + term_val;
    if (sum > SUM_MAX) field_next = SUM_MAX[FIELD_W-1:0];
    else if (sum < SUM_MIN) field_next = SUM_MIN[FIELD_W-1:0];
    else field_next = sum[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_sum  <= '0;
      site_valid <= 1'b0;
    end else begin
      if (accept) field_sum <= term.last_term ? '0 : field_next;
      if (accept && term.last_term) site_valid <= 1'b1;
      else if (down_ready) site_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && term.last_term) begin
      site.field           <= field_next;
      site.own_spin        <= term.own_spin;
      site.random_fraction <= term.random_fraction;
    end
  end

endmodule

@@ rtl/core/gsu_argument.sv @@
// gsu_argument: magnitude of the site field times beta, one multiplier and its register
// depends on gsu_pkg
module gsu_argument
  import gsu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [15:0]  beta,
  input  logic         up_valid,
  input  field_stage_t up,
  output logic         ready,
  output logic         arg_valid,
  output prod_stage_t  arg,
  input  logic         down_ready
);

  logic [FIELD_W-1:0] mag;

  assign ready = !arg_valid || down_ready;
  // most negative field gives 2^21, still fits unsigned
  assign mag = up.field[FIELD_W-1] ? (~up.field + FIELD_W'(1)) : up.field;

  always_ff @(posedge clk) begin
    if (rst) arg_valid <= 1'b0;
    else if (ready) arg_valid <= up_valid;
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      arg.product         <= PROD_W'(mag) * PROD_W'(beta);
      arg.positive        <= !up.field[FIELD_W-1] && (up.field != '0);
      arg.own_spin        <= up.own_spin;
      arg.random_fraction <= up.random_fraction;
    end
  end

endmodule

@@ rtl/core/gsu_tanh_lookup.sv @@
// gsu_tanh_lookup: saturates x to 8.0, indexes the tanh rom, registered read
// depends on gsu_pkg (tanh_entry builds the rom at elaboration)
module gsu_tanh_lookup
  import gsu_pkg::*;
#(
  parameter int TANH_ENTRIES = TANH_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  input  prod_stage_t up,
  output logic        ready,
  output logic        tanh_valid,
  output tanh_stage_t tanh_out,
  input  logic        down_ready
);

  localparam int IDX_W = $clog2(TANH_ENTRIES);
  localparam int SCALE_W = 16 + $clog2(TANH_ENTRIES + 1);
  localparam int MAG_W = PROD_W - 12;

  logic [15:0]        rom [TANH_ENTRIES];
  logic [MAG_W-1:0]   mag_wide;
  logic [15:0]        mag;
  logic [SCALE_W-1:0] scaled;
  logic [SCALE_W-1:0] idx_wide;
  logic [IDX_W-1:0]   idx;

  for (genvar i = 0; i < TANH_ENTRIES; i++) begin : g_rom
    localparam logic [15:0] ENTRY = tanh_entry(i, TANH_ENTRIES);
    assign rom[i] = ENTRY;
  end

  always_comb begin
    mag_wide = up.product[PROD_W-1:12];
    mag = (mag_wide > MAG_W'(X_SAT)) ? X_SAT : mag_wide[15:0];
    scaled = SCALE_W'(mag) * SCALE_W'(TANH_ENTRIES);
    idx_wide = scaled >> 15;
    idx = (idx_wide >= SCALE_W'(TANH_ENTRIES)) ? IDX_W'(TANH_ENTRIES - 1)
                                               : idx_wide[IDX_W-1:0];
  end

  assign ready = !tanh_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) tanh_valid <= 1'b0;
    else if (ready) tanh_valid <= up_valid;
  end

  always_ff @(posedge clk) begin
    if (ready && up_valid) begin
      tanh_out.tanh_value      <= rom[idx];
      tanh_out.zero            <= (mag == '0);
      // same sign of spin and field lowers the flip probability
      tanh_out.minus           <= (mag != '0) && (up.positive == up.own_spin);
      tanh_out.own_spin        <= up.own_spin;
      tanh_out.random_fraction <= up.random_fraction;
    end
  end

endmodule

@@ rtl/core/glauber_spin_update.sv @@
// glauber_spin_update: top level, beta register, flip decision and result register
// depends on gsu_pkg, gsu_accum, gsu_argument, gsu_tanh_lookup
//
// usage:
//   term channel: one neighbour term per transaction (term_valid / term_stall).
//   every term is added into the saturating local field; the term with last_term
//   set closes the site and produces exactly one result transaction.
//   a site with no neighbours is sent as one zero-coupling last term.
//   result channel: result_valid / result_stall carry new_spin, flipped and
//   flip_probability.
//   temp_write / temp_data set beta (unsigned Q4.12); write only while idle.
// timing:
//   one term per cycle sustained while term_stall is low. four register stages: site
//   field, |field|*beta product, tanh rom read, result register. once the site field
//   register takes the last term, the result moves through the later registers in order.
// stall:
//   each stage holds while the next is full and stalled; term_stall rises only
//   once the stage holding a finished site field cannot move on.
// reset:
//   rst clears the field sum, all stage valids and sets beta to 1.0.
module glauber_spin_update
  import gsu_pkg::*;
#(
  parameter int TANH_ENTRIES = TANH_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        temp_write,
  input  logic [15:0] temp_data,
  input  logic        term_valid,
  output logic        term_stall,
  input  term_t       term,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  logic [15:0]  beta;
  logic         accum_ready;
  logic         site_valid;
  field_stage_t site;
  logic         arg_ready;
  logic         arg_valid;
  prod_stage_t  arg;
  logic         lookup_ready;
  logic         tanh_valid;
  tanh_stage_t  tanh_res;
  logic         out_ready;
  logic [15:0]  t;
  logic [16:0]  prob;
  logic         flip;

  always_ff @(posedge clk) begin
    if (rst) beta <= BETA_RESET;
    else if (temp_write) beta <= temp_data;
  end

  gsu_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .term_valid (term_valid),
    .term       (term),
    .ready      (accum_ready),
    .site_valid (site_valid),
    .site       (site),
    .down_ready (arg_ready)
  );

  gsu_argument u_argument (
    .clk        (clk),
    .rst        (rst),
    .beta       (beta),
    .up_valid   (site_valid),
    .up         (site),
    .ready      (arg_ready),
    .arg_valid  (arg_valid),
    .arg        (arg),
    .down_ready (lookup_ready)
  );

  gsu_tanh_lookup #(
    .TANH_ENTRIES (TANH_ENTRIES)
  ) u_tanh_lookup (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (arg_valid),
    .up         (arg),
    .ready      (lookup_ready),
    .tanh_valid (tanh_valid),
    .tanh_out   (tanh_res),
    .down_ready (out_ready)
  );

  assign term_stall = !accum_ready;
  assign out_ready  = !result_valid || !result_stall;

  always_comb begin
    t = tanh_res.zero ? 16'd0 : tanh_res.tanh_value;
    if (tanh_res.minus) prob = (ONE_Q16 - 17'(t)) >> 1;
    else prob = (ONE_Q16 + 17'(t)) >> 1;
    flip = prob > 17'(tanh_res.random_fraction);
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (out_ready) result_valid <= tanh_valid;
  end

  always_ff @(posedge clk) begin
    if (out_ready && tanh_valid) begin
      result.new_spin         <= tanh_res.own_spin ^ flip;
      result.flipped          <= flip;
      result.flip_probability <= prob;
    end
  end

`ifndef SYNTH
  // a term that does not close a site never starts a result
  a_no_site_without_last: assert property (@(posedge clk) disable iff (rst)
    term_valid && !term_stall && !term.last_term && !site_valid |=> !site_valid)
    else $error("site field captured without a last term");

  // halving keeps the probability below one
  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !result.flip_probability[16])
    else $error("flip probability out of range");

  // a new result only comes from the lookup stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(tanh_valid))
    else $error("result without a lookup stage transaction");
`endif

endmodule
